// ===== src/tmcr_pkg.sv =====
package tmcr_pkg;

	// Item kinds as they arrive on the input channel.
	localparam logic [2:0] KIND_WRITE   = 3'd0;
	localparam logic [2:0] KIND_FONT    = 3'd1;
	localparam logic [2:0] KIND_PALETTE = 3'd2;
	localparam logic [2:0] KIND_RENDER  = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam int GLYPH_W = 6;
	localparam int COLOR_W = 16;
	localparam int CELL_W  = 16;
	localparam int PAL_DEPTH = 16;

	// Mask that picks the foreground index out of an attribute byte.
	localparam logic [7:0] ATTR_FG_MASK = 8'h0f;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_FONT,
		OP_PALETTE,
		OP_RENDER,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// One classified transaction as it waits in the queue.
	typedef struct packed {
		op_t         op;
		logic        in_grid;
		logic        line_ok;
		logic [4:0]  col;
		logic [3:0]  row;
		logic [2:0]  glyph_line;
		logic [7:0]  char_code;
		logic [7:0]  attr;
		logic [5:0]  font_bits;
		logic [3:0]  palette_index;
		logic        palette_column;
		logic [15:0] color;
	} cmd_t;

endpackage

// ===== src/tmcr_ram.sv =====
module tmcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/tmcr_front.sv =====
module tmcr_front import tmcr_pkg::*; #(
	parameter int COLS       = 32,
	parameter int ROWS       = 16,
	parameter int GLYPH_ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  col,
	input  logic [3:0]  row,
	input  logic [2:0]  glyph_line,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [5:0]  font_bits,
	input  logic [3:0]  palette_index,
	input  logic        palette_column,
	input  logic [15:0] color,
	input  logic        busy,
	output logic        q_valid,
	output cmd_t        q_cmd,
	input  logic        q_pop
);

	cmd_t       cmd;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// Decode the kind and work out the range checks once, up front.
	always_comb begin
		cmd = '0;
		case (kind)
			KIND_WRITE:   cmd.op = OP_WRITE;
			KIND_FONT:    cmd.op = OP_FONT;
			KIND_PALETTE: cmd.op = OP_PALETTE;
			KIND_RENDER:  cmd.op = OP_RENDER;
			KIND_CLEAR:   cmd.op = OP_CLEAR;
			default:      cmd.op = OP_NOP;
		endcase
		cmd.in_grid        = (int'(col) < COLS) && (int'(row) < ROWS);
		cmd.line_ok        = int'(glyph_line) < GLYPH_ROWS;
		cmd.col            = col;
		cmd.row            = row;
		cmd.glyph_line     = glyph_line;
		cmd.char_code      = char_code;
		cmd.attr           = attr;
		cmd.font_bits      = font_bits;
		cmd.palette_index  = palette_index;
		cmd.palette_column = palette_column;
		cmd.color          = color;
	end

	assign item_stall = (cnt_q == 2'd2) || busy;
	assign push       = item_valid && !item_stall;
	assign q_valid    = cnt_q != 2'd0;
	assign q_cmd      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, q_pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

// ===== src/tmcr_back.sv =====
module tmcr_back import tmcr_pkg::*; #(
	parameter int COLS       = 32,
	parameter int ROWS       = 16,
	parameter int GLYPH_ROWS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  cmd_t                            q_cmd,
	output logic                            q_pop,
	output logic                            busy,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [GLYPH_W-1:0][COLOR_W-1:0] pixels,
	output logic                            pixels_valid,
	output logic [5:0]                      dirty_left,
	output logic [4:0]                      dirty_top,
	output logic [5:0]                      dirty_right,
	output logic [4:0]                      dirty_bottom
);

	localparam int CELL_DEPTH = COLS * ROWS;
	localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int FONT_DEPTH = 256 * GLYPH_ROWS;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int PAL_AW     = $clog2(PAL_DEPTH);
	localparam int CW         = $clog2(COLS + 1);
	localparam int RW         = $clog2(ROWS + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_GLYPH
	} state_t;

	state_t               state_q;
	logic [CELL_AW-1:0]   clr_cnt_q;
	cmd_t                 cmd_q;
	logic [CW-1:0]        box_left_q, box_right_q;
	logic [RW-1:0]        box_top_q, box_bottom_q;
	logic [CW-1:0]        nb_left, nb_right, c0, c1;
	logic [RW-1:0]        nb_top, nb_bottom, r0, r1;
	logic                 out_free;
	logic                 pop;

	logic                 cell_we, cell_re;
	logic [CELL_AW-1:0]   cell_waddr, cell_raddr;
	logic [CELL_W-1:0]    cell_wdata, cell_rdata;
	logic                 font_we, font_re;
	logic [FONT_AW-1:0]   font_waddr, font_raddr;
	logic [GLYPH_W-1:0]   font_rdata;
	logic                 fg_we, bg_we, pal_re;
	logic [PAL_AW-1:0]    fg_raddr, bg_raddr;
	logic [COLOR_W-1:0]   fg_rdata, bg_rdata;
	logic [7:0]           cur_char, cur_attr;
	logic [GLYPH_W-1:0]   glyph_bits;
	logic [GLYPH_W-1:0][COLOR_W-1:0] pix_next;

	assign busy     = state_q == ST_CLEAR;
	assign out_free = !result_valid || !result_stall;
	assign pop      = (state_q == ST_IDLE) && q_valid &&
		((q_cmd.op == OP_RENDER) || out_free);
	assign q_pop    = pop;

	// Store controls. The clearing pass owns the cell store's write port.
	always_comb begin
		cell_we    = busy || (pop && (q_cmd.op == OP_WRITE) && q_cmd.in_grid);
		cell_waddr = busy ? clr_cnt_q :
			CELL_AW'(int'(q_cmd.row) * COLS + int'(q_cmd.col));
		cell_wdata = busy ? '0 : {q_cmd.char_code, q_cmd.attr};
		cell_re    = pop && (q_cmd.op == OP_RENDER);
		cell_raddr = CELL_AW'(int'(q_cmd.row) * COLS + int'(q_cmd.col));

		font_we    = pop && (q_cmd.op == OP_FONT) && q_cmd.line_ok;
		font_waddr = FONT_AW'(int'(q_cmd.char_code) * GLYPH_ROWS +
			int'(q_cmd.glyph_line));

		fg_we = pop && (q_cmd.op == OP_PALETTE) && !q_cmd.palette_column;
		bg_we = pop && (q_cmd.op == OP_PALETTE) && q_cmd.palette_column;

		// Cells outside the grid read as character zero, attribute zero.
		cur_char = cmd_q.in_grid ? cell_rdata[15:8] : 8'd0;
		cur_attr = cmd_q.in_grid ? cell_rdata[7:0] : 8'd0;
		font_re    = state_q == ST_CELL;
		pal_re     = state_q == ST_CELL;
		font_raddr = FONT_AW'(int'(cur_char) * GLYPH_ROWS + int'(cmd_q.glyph_line));
		fg_raddr   = PAL_AW'(cur_attr & ATTR_FG_MASK);
		bg_raddr   = PAL_AW'(cur_attr >> 4);

		glyph_bits = cmd_q.line_ok ? font_rdata : '0;
		for (int i = 0; i < GLYPH_W; i++) begin
			pix_next[i] = glyph_bits[i] ? fg_rdata : bg_rdata;
		end
	end

	// Dirty box after the item at the head of the queue.
	always_comb begin
		c0 = (int'(q_cmd.col) > COLS) ? CW'(COLS) : CW'(q_cmd.col);
		c1 = (int'(q_cmd.col) + 1 > COLS) ? CW'(COLS) : CW'(int'(q_cmd.col) + 1);
		r0 = (int'(q_cmd.row) > ROWS) ? RW'(ROWS) : RW'(q_cmd.row);
		r1 = (int'(q_cmd.row) + 1 > ROWS) ? RW'(ROWS) : RW'(int'(q_cmd.row) + 1);
		nb_left   = box_left_q;
		nb_top    = box_top_q;
		nb_right  = box_right_q;
		nb_bottom = box_bottom_q;
		case (q_cmd.op)
			OP_WRITE: begin
				if (c0 < box_left_q) nb_left = c0;
				if (r0 < box_top_q) nb_top = r0;
				if (c1 > box_right_q) nb_right = c1;
				if (r1 > box_bottom_q) nb_bottom = r1;
			end
			OP_CLEAR: begin
				nb_left   = CW'(COLS);
				nb_top    = RW'(ROWS);
				nb_right  = '0;
				nb_bottom = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= CW'(COLS);
			box_bottom_q <= RW'(ROWS);
			result_valid <= 1'b0;
			pixels       <= '0;
			pixels_valid <= 1'b0;
			dirty_left   <= '0;
			dirty_top    <= '0;
			dirty_right  <= '0;
			dirty_bottom <= '0;
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= CELL_AW'(clr_cnt_q + 1'b1);
					if (clr_cnt_q == CELL_AW'(CELL_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (q_cmd.op == OP_RENDER) begin
							state_q <= ST_CELL;
						end else begin
							box_left_q   <= nb_left;
							box_top_q    <= nb_top;
							box_right_q  <= nb_right;
							box_bottom_q <= nb_bottom;
							result_valid <= 1'b1;
							pixels       <= '0;
							pixels_valid <= 1'b0;
							dirty_left   <= 6'(nb_left);
							dirty_top    <= 5'(nb_top);
							dirty_right  <= 6'(nb_right);
							dirty_bottom <= 5'(nb_bottom);
						end
					end
				end
				ST_CELL: begin
					state_q <= ST_GLYPH;
				end
				ST_GLYPH: begin
					if (out_free) begin
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
						pixels       <= pix_next;
						pixels_valid <= 1'b1;
						dirty_left   <= 6'(box_left_q);
						dirty_top    <= 5'(box_top_q);
						dirty_right  <= 6'(box_right_q);
						dirty_bottom <= 5'(box_bottom_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The render waiting on its cell, glyph and palette reads.
	always_ff @(posedge clk) begin
		if (pop && (q_cmd.op == OP_RENDER)) begin
			cmd_q <= q_cmd;
		end
	end

	tmcr_ram #(.WIDTH(CELL_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
		.clk     (clk),
		.wr_en   (cell_we),
		.wr_addr (cell_waddr),
		.wr_data (cell_wdata),
		.rd_en   (cell_re),
		.rd_addr (cell_raddr),
		.rd_data (cell_rdata)
	);

	tmcr_ram #(.WIDTH(GLYPH_W), .DEPTH(FONT_DEPTH)) u_font_ram (
		.clk     (clk),
		.wr_en   (font_we),
		.wr_addr (font_waddr),
		.wr_data (q_cmd.font_bits),
		.rd_en   (font_re),
		.rd_addr (font_raddr),
		.rd_data (font_rdata)
	);

	tmcr_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_fg_ram (
		.clk     (clk),
		.wr_en   (fg_we),
		.wr_addr (q_cmd.palette_index),
		.wr_data (q_cmd.color),
		.rd_en   (pal_re),
		.rd_addr (fg_raddr),
		.rd_data (fg_rdata)
	);

	tmcr_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_bg_ram (
		.clk     (clk),
		.wr_en   (bg_we),
		.wr_addr (q_cmd.palette_index),
		.wr_data (q_cmd.color),
		.rd_en   (pal_re),
		.rd_addr (bg_raddr),
		.rd_data (bg_rdata)
	);

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pop)
		else $error("queue popped during the cell clearing pass");

	a_cell_to_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |=> (state_q == ST_GLYPH))
		else $error("render did not move on to the glyph read");

	a_render_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_GLYPH) && out_free) |=> (result_valid && pixels_valid))
		else $error("finished render did not produce a pixel result");

	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (q_cmd.op != OP_RENDER)) |=>
		(result_valid && !pixels_valid && (state_q == ST_IDLE)))
		else $error("non-render transaction did not produce a plain result");

endmodule

// ===== src/text_mode_cell_renderer.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// item      | item_valid / item_stall    | kind, col, row, glyph_line, char_code, attr,
//           |                            | font_bits, palette_index, palette_column, color
// result    | result_valid / result_stall| pixel_0..pixel_5, pixels_valid,
//           |                            | dirty_left, dirty_top, dirty_right, dirty_bottom
//
// Writes, font loads, palette loads, clears and unused kinds finish in the idle state of the
// back part, so a run of them moves at one transaction per cycle while no result stalls.
// A render goes through a cell store read, then glyph and palette reads, then the result
// register; each read depends on the one before it, which sets that order.
// After reset the cell store is swept to zero, one cell per cycle, over all COLS*ROWS cells
// (512 at the default size); item_stall stays high for that time.
// A two-entry queue parts the front from the back, and the result register parts the back
// from the output. A stalled result holds the back part at once, and it reaches
// item_stall only once the queue fills.
module text_mode_cell_renderer import tmcr_pkg::*; #(
	parameter int COLS       = 32,
	parameter int ROWS       = 16,
	parameter int GLYPH_ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  col,
	input  logic [3:0]  row,
	input  logic [2:0]  glyph_line,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [5:0]  font_bits,
	input  logic [3:0]  palette_index,
	input  logic        palette_column,
	input  logic [15:0] color,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] pixel_0,
	output logic [15:0] pixel_1,
	output logic [15:0] pixel_2,
	output logic [15:0] pixel_3,
	output logic [15:0] pixel_4,
	output logic [15:0] pixel_5,
	output logic        pixels_valid,
	output logic [5:0]  dirty_left,
	output logic [4:0]  dirty_top,
	output logic [5:0]  dirty_right,
	output logic [4:0]  dirty_bottom
);

	// Classified transactions waiting for the back part.
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// High while the back part sweeps the cell store after reset.
	logic busy;

	logic [GLYPH_W-1:0][COLOR_W-1:0] pixels;

	// The front decodes the kind, checks the cell and glyph line ranges and queues
	// the transaction.
	tmcr_front #(
		.COLS       (COLS),
		.ROWS       (ROWS),
		.GLYPH_ROWS (GLYPH_ROWS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.col            (col),
		.row            (row),
		.glyph_line     (glyph_line),
		.char_code      (char_code),
		.attr           (attr),
		.font_bits      (font_bits),
		.palette_index  (palette_index),
		.palette_column (palette_column),
		.color          (color),
		.busy           (busy),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop)
	);

	// The back owns the cell, font and palette stores and the dirty box, and
	// builds every result in its output register.
	tmcr_back #(
		.COLS       (COLS),
		.ROWS       (ROWS),
		.GLYPH_ROWS (GLYPH_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixels       (pixels),
		.pixels_valid (pixels_valid),
		.dirty_left   (dirty_left),
		.dirty_top    (dirty_top),
		.dirty_right  (dirty_right),
		.dirty_bottom (dirty_bottom)
	);

	// Pixel 0 is the leftmost one and takes bit 0 of the glyph row.
	assign pixel_0 = pixels[0];
	assign pixel_1 = pixels[1];
	assign pixel_2 = pixels[2];
	assign pixel_3 = pixels[3];
	assign pixel_4 = pixels[4];
	assign pixel_5 = pixels[5];

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the text-mode cell renderer.
// A short list of hand-written transactions comes first; a long random stream follows.
// Every accepted transaction is run through a shadow copy of the renderer kept here,
// and each result the block returns is compared field by field with the oldest
// prediction still waiting.
module tb_top;
	import tmcr_pkg::*;

	// Geometry of the instance under test (default parameters).
	localparam int GRID_COLS       = 32;
	localparam int GRID_ROWS       = 16;
	localparam int LINES_PER_GLYPH = 8;
	localparam int GLYPH_CODES     = 256;

	// Kinds the block must treat as no-ops.
	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	// Shape of the random part of the run.
	localparam int RANDOM_OPS      = 1880;
	localparam int CALM_TAIL       = 200;   // last transactions sent with no idling at all
	localparam int HOLD_OFF_AT     = 500;   // accepted count that starts the long output stall
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int DRAIN_AT        = 1200;  // random index where the sender waits for a drain

	// One input transaction, field for field as on the item channel.
	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  col;
		logic [3:0]  row;
		logic [2:0]  glyph_line;
		logic [7:0]  char_code;
		logic [7:0]  attr;
		logic [5:0]  font_bits;
		logic [3:0]  palette_index;
		logic        palette_column;
		logic [15:0] color;
	} cell_op_t;

	// One result transaction. px[0] is the leftmost pixel.
	typedef struct packed {
		logic [5:0][15:0] px;
		logic             lit;
		logic [5:0]       box_left;
		logic [4:0]       box_top;
		logic [5:0]       box_right;
		logic [4:0]       box_bottom;
	} line_result_t;

	// A row of the directed list: the transaction, and optionally its answer typed in.
	typedef struct {
		cell_op_t     op;
		bit           typed;
		line_result_t golden;
	} directed_row_t;

	logic clk;
	logic arst_n = 1'b0;

	// Item channel. The payload lives in one struct so it changes in a single assignment.
	cell_op_t     drive_op     = '0;
	logic         item_valid   = 1'b0;
	bit           drive_typed  = 1'b0;
	line_result_t drive_golden = '0;
	logic         item_stall;

	logic [2:0]  kind;
	logic [4:0]  col;
	logic [3:0]  row;
	logic [2:0]  glyph_line;
	logic [7:0]  char_code;
	logic [7:0]  attr;
	logic [5:0]  font_bits;
	logic [3:0]  palette_index;
	logic        palette_column;
	logic [15:0] color;

	assign kind           = drive_op.kind;
	assign col            = drive_op.col;
	assign row            = drive_op.row;
	assign glyph_line     = drive_op.glyph_line;
	assign char_code      = drive_op.char_code;
	assign attr           = drive_op.attr;
	assign font_bits      = drive_op.font_bits;
	assign palette_index  = drive_op.palette_index;
	assign palette_column = drive_op.palette_column;
	assign color          = drive_op.color;

	// Result channel.
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5;
	logic        pixels_valid;
	logic [5:0]  dirty_left;
	logic [4:0]  dirty_top;
	logic [5:0]  dirty_right;
	logic [4:0]  dirty_bottom;

	text_mode_cell_renderer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.col            (col),
		.row            (row),
		.glyph_line     (glyph_line),
		.char_code      (char_code),
		.attr           (attr),
		.font_bits      (font_bits),
		.palette_index  (palette_index),
		.palette_column (palette_column),
		.color          (color),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pixel_0        (pixel_0),
		.pixel_1        (pixel_1),
		.pixel_2        (pixel_2),
		.pixel_3        (pixel_3),
		.pixel_4        (pixel_4),
		.pixel_5        (pixel_5),
		.pixels_valid   (pixels_valid),
		.dirty_left     (dirty_left),
		.dirty_top      (dirty_top),
		.dirty_right    (dirty_right),
		.dirty_bottom   (dirty_bottom)
	);

	// Shadow state of the renderer. The *_loaded flags record which font and palette
	// entries hold a real value, so the stimulus never renders from an unwritten one.
	logic [7:0]  shadow_char [GRID_COLS*GRID_ROWS];
	logic [7:0]  shadow_attr [GRID_COLS*GRID_ROWS];
	logic [5:0]  glyph_rows [GLYPH_CODES*LINES_PER_GLYPH];
	bit          glyph_loaded [GLYPH_CODES*LINES_PER_GLYPH];
	logic [15:0] colors [2*PAL_DEPTH];
	bit          color_loaded [2*PAL_DEPTH];
	int          bx_l, bx_t, bx_r, bx_b;

	line_result_t  lines_pending[$];   // predicted results not yet returned by the block
	directed_row_t directed_rows[$];

	int  errors        = 0;
	int  items_taken   = 0;
	int  results_seen  = 0;
	int  kind_count [8];
	bit  calm          = 1'b0;   // set for the tail of the run: nobody idles
	bit  hold_off_busy = 1'b0;   // the receiver is in its long stall

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is released on a falling edge, away from the rising edge.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// The cell store comes out of reset cleared and the whole screen counts as dirty.
	initial begin
		foreach (shadow_char[i]) begin
			shadow_char[i] = '0;
			shadow_attr[i] = '0;
		end
		foreach (glyph_rows[i]) glyph_rows[i] = '0;
		foreach (colors[i]) colors[i] = '0;
		foreach (kind_count[i]) kind_count[i] = 0;
		bx_l = 0;
		bx_t = 0;
		bx_r = GRID_COLS;
		bx_b = GRID_ROWS;
	end

	// Applies one accepted transaction to the shadow state and returns the result
	// the block owes for it.
	function automatic line_result_t render_and_track(input cell_op_t op);
		line_result_t res;
		int           cell_idx, c1, r1, fg_slot, bg_slot, slot;
		logic [7:0]   ch, at;
		logic [5:0]   bits;
		res = '0;
		cell_idx = int'(op.row) * GRID_COLS + int'(op.col);
		case (op.kind)
			KIND_WRITE: begin
				shadow_char[cell_idx] = op.char_code;
				shadow_attr[cell_idx] = op.attr;
				// The box only ever grows on a write; the far edges are exclusive.
				c1 = (int'(op.col) + 1 > GRID_COLS) ? GRID_COLS : int'(op.col) + 1;
				r1 = (int'(op.row) + 1 > GRID_ROWS) ? GRID_ROWS : int'(op.row) + 1;
				if (int'(op.col) < bx_l) bx_l = int'(op.col);
				if (int'(op.row) < bx_t) bx_t = int'(op.row);
				if (c1 > bx_r) bx_r = c1;
				if (r1 > bx_b) bx_b = r1;
			end
			KIND_FONT: begin
				if (op.glyph_line < LINES_PER_GLYPH) begin
					slot = int'(op.char_code) * LINES_PER_GLYPH + int'(op.glyph_line);
					glyph_rows[slot] = op.font_bits;
					glyph_loaded[slot] = 1'b1;
				end
			end
			KIND_PALETTE: begin
				slot = int'(op.palette_index) * 2 + int'(op.palette_column);
				colors[slot] = op.color;
				color_loaded[slot] = 1'b1;
			end
			KIND_RENDER: begin
				ch = shadow_char[cell_idx];
				at = shadow_attr[cell_idx];
				bits = glyph_rows[int'(ch) * LINES_PER_GLYPH + int'(op.glyph_line)];
				// Foreground comes from column 0, background from column 1.
				fg_slot = int'(at & ATTR_FG_MASK) * 2;
				bg_slot = int'(at >> 4) * 2 + 1;
				for (int i = 0; i < GLYPH_W; i++)
					res.px[i] = bits[i] ? colors[fg_slot] : colors[bg_slot];
				res.lit = 1'b1;
			end
			KIND_CLEAR: begin
				// An empty box: left and top at the far edges, right and bottom at zero.
				bx_l = GRID_COLS;
				bx_t = GRID_ROWS;
				bx_r = 0;
				bx_b = 0;
			end
			default: ;
		endcase
		res.box_left   = 6'(bx_l);
		res.box_top    = 5'(bx_t);
		res.box_right  = 6'(bx_r);
		res.box_bottom = 5'(bx_b);
		return res;
	endfunction

	// A non-render answer or a render with all six pixels the same color.
	function automatic line_result_t typed_res(input logic [15:0] px, input logic lit,
			input int l, input int t, input int r, input int b);
		line_result_t res;
		for (int i = 0; i < GLYPH_W; i++) res.px[i] = px;
		res.lit        = lit;
		res.box_left   = 6'(l);
		res.box_top    = 5'(t);
		res.box_right  = 6'(r);
		res.box_bottom = 5'(b);
		return res;
	endfunction

	task automatic add_row(input logic [2:0] k, input int c, input int r, input int gl,
			input int ch, input int at, input int fb, input int pi, input int pc,
			input int clr, input bit typed, input line_result_t golden);
		directed_row_t dr;
		dr.op.kind           = k;
		dr.op.col            = 5'(c);
		dr.op.row            = 4'(r);
		dr.op.glyph_line     = 3'(gl);
		dr.op.char_code      = 8'(ch);
		dr.op.attr           = 8'(at);
		dr.op.font_bits      = 6'(fb);
		dr.op.palette_index  = 4'(pi);
		dr.op.palette_column = 1'(pc);
		dr.op.color          = 16'(clr);
		dr.typed             = typed;
		dr.golden            = golden;
		directed_rows.push_back(dr);
	endtask

	// Draws a random transaction. A render that would read a font row or palette entry
	// never loaded is turned into the load that fills it, so the stream stays legal
	// while the stores fill up with random content.
	task automatic make_random_op(output cell_op_t op);
		int         pick, cell_idx;
		logic [7:0] ch, at;
		op.col            = 5'($urandom_range(0, GRID_COLS - 1));
		op.row            = 4'($urandom_range(0, GRID_ROWS - 1));
		op.glyph_line     = 3'($urandom_range(0, LINES_PER_GLYPH - 1));
		// Most characters come from a small set so renders find loaded glyphs often.
		op.char_code      = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15))
		                                               : 8'($urandom_range(0, 255));
		op.attr           = 8'($urandom_range(0, 255));
		op.font_bits      = 6'($urandom_range(0, 63));
		op.palette_index  = 4'($urandom_range(0, 15));
		op.palette_column = 1'($urandom_range(0, 1));
		op.color          = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 28) op.kind = KIND_WRITE;
		else if (pick < 43) op.kind = KIND_FONT;
		else if (pick < 53) op.kind = KIND_PALETTE;
		else if (pick < 90) op.kind = KIND_RENDER;
		else if (pick < 95) op.kind = KIND_CLEAR;
		else op.kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
		if (op.kind == KIND_RENDER) begin
			cell_idx = int'(op.row) * GRID_COLS + int'(op.col);
			ch = shadow_char[cell_idx];
			at = shadow_attr[cell_idx];
			if (!glyph_loaded[int'(ch) * LINES_PER_GLYPH + int'(op.glyph_line)]) begin
				op.kind = KIND_FONT;
				op.char_code = ch;
			end else if (!color_loaded[int'(at & ATTR_FG_MASK) * 2]) begin
				op.kind = KIND_PALETTE;
				op.palette_index = at[3:0];
				op.palette_column = 1'b0;
			end else if (!color_loaded[int'(at >> 4) * 2 + 1]) begin
				op.kind = KIND_PALETTE;
				op.palette_index = at[7:4];
				op.palette_column = 1'b1;
			end
		end
	endtask

	// Waits for a falling edge. Sometimes lets the item channel go idle for a short burst.
	// No gaps while the receiver is in its long stall, so the block backs up.
	task automatic pace();
		@(negedge clk);
		if (!calm && !hold_off_busy && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Puts one transaction on the item channel and holds it until the block takes it.
	task automatic present(input cell_op_t op, input bit typed, input line_result_t golden);
		drive_op     <= op;
		drive_typed  <= typed;
		drive_golden <= golden;
		item_valid   <= 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Both handshakes are sampled here at the rising edge. A returned result is matched
	// first, then a newly accepted transaction is predicted and queued.
	always @(posedge clk) begin : scoreboard
		line_result_t got, want, predicted;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got.px         = {pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
				got.lit        = pixels_valid;
				got.box_left   = dirty_left;
				got.box_top    = dirty_top;
				got.box_right  = dirty_right;
				got.box_bottom = dirty_bottom;
				results_seen++;
				if (lines_pending.size() == 0) begin
					$error("result transaction arrived with nothing outstanding");
					errors++;
				end else begin
					want = lines_pending.pop_front();
					for (int i = 0; i < GLYPH_W; i++)
						check_field($sformatf("pixel_%0d", i), want.px[i], got.px[i]);
					check_field("pixels_valid", 16'(want.lit), 16'(got.lit));
					check_field("dirty_left", 16'(want.box_left), 16'(got.box_left));
					check_field("dirty_top", 16'(want.box_top), 16'(got.box_top));
					check_field("dirty_right", 16'(want.box_right), 16'(got.box_right));
					check_field("dirty_bottom", 16'(want.box_bottom), 16'(got.box_bottom));
				end
			end
			if (item_valid && !item_stall) begin
				// The shadow state always advances; a typed-in answer, where the row
				// has one, replaces the computed one as the thing to compare against.
				predicted = render_and_track(drive_op);
				lines_pending.push_back(drive_typed ? drive_golden : predicted);
				items_taken++;
				kind_count[drive_op.kind]++;
			end
		end
	end

	// Output side. Short random stalls, one long hold-off counted here, and none at the
	// end. Exactly one assignment to result_stall per falling edge.
	initial begin : sink
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_taken >= HOLD_OFF_AT) begin
				hold_done = 1'b1;
				hold_off_busy = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				hold_off_busy = 1'b0;
				if (!calm && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(0, 5);
					result_stall <= 1'b1;
				end else begin
					result_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		cell_op_t op;
		int       guard;

		// Directed list. Palette and font entries are loaded before any render reads
		// them. Answers are typed in for most non-render rows and for some renders whose six
		// pixels are all one color; the rest go through the shadow renderer.
		add_row(KIND_PALETTE, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_PALETTE, 0, 0, 0, 0, 0, 0, 0, 1, 'h0000, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_PALETTE, 0, 0, 0, 0, 0, 0, 15, 0, 'hF800, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_PALETTE, 0, 0, 0, 0, 0, 0, 15, 1, 'h001F, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_FONT, 0, 0, 0, 0, 0, 'h3F, 0, 0, 0, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_FONT, 0, 0, 7, 0, 0, 'h00, 0, 0, 0, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		// Cells read as character 0, attribute 0 straight after reset.
		add_row(KIND_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('hFFFF, 1, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_RENDER, 31, 15, 7, 0, 0, 0, 0, 0, 0, 1,
			typed_res('h0000, 1, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_FONT, 0, 0, 7, 255, 0, 'h21, 0, 0, 0, 0, '0);
		add_row(KIND_WRITE, 31, 15, 0, 255, 'hFF, 0, 0, 0, 0, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_RENDER, 31, 15, 7, 0, 0, 0, 0, 0, 0, 0, '0);
		add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, GRID_COLS, GRID_ROWS, 0, 0));
		add_row(KIND_SPARE_5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, GRID_COLS, GRID_ROWS, 0, 0));
		// A write into an empty box sets it to exactly that cell.
		add_row(KIND_WRITE, 31, 15, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, 31, 15, GRID_COLS, GRID_ROWS));
		add_row(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, 0, 0, GRID_COLS, GRID_ROWS));
		add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, GRID_COLS, GRID_ROWS, 0, 0));
		add_row(KIND_WRITE, 5, 3, 0, 0, 'h0F, 0, 0, 0, 0, 1,
			typed_res('0, 0, 5, 3, 6, 4));
		add_row(KIND_RENDER, 5, 3, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		add_row(KIND_SPARE_6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, 5, 3, 6, 4));
		add_row(KIND_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			typed_res('0, 0, 5, 3, 6, 4));
		add_row(KIND_FONT, 0, 0, 3, 0, 0, 'h2A, 0, 0, 0, 0, '0);
		add_row(KIND_RENDER, 1, 1, 3, 0, 0, 0, 0, 0, 0, 0, '0);
		add_row(KIND_PALETTE, 0, 0, 0, 0, 0, 0, 7, 1, 'h5555, 1,
			typed_res('0, 0, 5, 3, 6, 4));

		// The block stalls its input while it sweeps the cell store after reset; the
		// first transaction simply waits on the handshake.
		@(posedge arst_n);
		foreach (directed_rows[i]) begin
			pace();
			present(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].golden);
		end

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == DRAIN_AT) begin
				// Let the block run completely dry once before going on.
				@(negedge clk);
				item_valid <= 1'b0;
				while (lines_pending.size() != 0) @(negedge clk);
			end
			calm = (n >= RANDOM_OPS - CALM_TAIL);
			// pace() ends on a falling edge, after the scoreboard has absorbed the
			// previous transaction, so the legality check sees current state.
			pace();
			make_random_op(op);
			present(op, 1'b0, '0);
		end

		@(negedge clk);
		item_valid <= 1'b0;
		guard = 0;
		while (lines_pending.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		// Keep the clock running past the drain to catch any stray result after the last one.
		repeat (20) @(posedge clk);
		if (lines_pending.size() != 0) begin
			$error("%0d result transactions never arrived", lines_pending.size());
			errors++;
		end

		$display("Run summary: %0d transactions in, %0d results compared.",
			items_taken, results_seen);
		$display("  %0d renders, %0d cell writes, %0d font rows, %0d colors, %0d clears.",
			kind_count[KIND_RENDER], kind_count[KIND_WRITE], kind_count[KIND_FONT],
			kind_count[KIND_PALETTE], kind_count[KIND_CLEAR]);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
